// ===== src/u2pd_pkg.sv =====
package u2pd_pkg;

  // fixed field widths
  localparam int VAL_W  = 16;
  localparam int MIN_W  = 4;
  localparam int CHAR_W = 7;

  // defaults for the top level parameters
  localparam int DEF_MAX_DIGITS = 6;
  localparam int DEF_VALUE_BITS = 16;

  // transaction queue between front and back
  localparam int Q_DEPTH = 2;

  // divide by ten: q = (x * DIV10_MAGIC) >> DIV10_SHIFT, exact for 16-bit x
  localparam logic [VAL_W-1:0] DIV10_MAGIC = 16'hCCCD;
  localparam int               DIV10_SHIFT = 19;

  // character codes
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h30;
  localparam logic [CHAR_W-1:0] ERROR_CHAR = 7'h58;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [MIN_W-1:0] min_digits;
  } num_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_precision;
  } chr_t;

endpackage

// ===== src/u2pd_front.sv =====
module u2pd_front #(
  parameter int MAX_DIGITS = u2pd_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_BITS = u2pd_pkg::DEF_VALUE_BITS,
  localparam int TOT_W = $clog2(MAX_DIGITS + 1),
  localparam int CNT_W = $clog2(MAX_DIGITS),
  localparam int ENT_W = 1 + TOT_W + 4 * MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_valid,
  output logic              num_ready,
  input  u2pd_pkg::num_t    num,
  output logic              ent_push,
  input  logic              ent_full,
  output logic [ENT_W-1:0]  ent
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam int VW = u2pd_pkg::VAL_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_DIGITS - 1);
  localparam logic [u2pd_pkg::MIN_W-1:0] MAX_MIN = u2pd_pkg::MIN_W'(MAX_DIGITS);
  localparam logic [VW-1:0] VAL_MASK = (VALUE_BITS >= VW) ? {VW{1'b1}} :
                                       VW'((64'd1 << VALUE_BITS) - 64'd1);

  logic [1:0]                      state;
  logic [CNT_W-1:0]                cnt;
  logic [VW-1:0]                   work;
  logic [MAX_DIGITS-1:0][3:0]      digits;
  logic [TOT_W-1:0]                used;
  logic [u2pd_pkg::MIN_W-1:0]      min_r;
  logic                            err_r;

  logic [2*VW-1:0]                 prod;
  logic [VW-1:0]                   quot;
  logic [VW-1:0]                   quot10;
  logic [VW-1:0]                   rem_w;
  logic [3:0]                      rem;
  logic                            last;
  logic                            accept;
  logic                            is_err;
  logic [MAX_DIGITS-1:0][3:0]      dig_fin;
  logic [TOT_W-1:0]                used_fin;
  logic [MAX_DIGITS-1:0][3:0]      sel_digits;
  logic [TOT_W-1:0]                sel_used;
  logic [TOT_W-1:0]                total;

  // one decimal digit per cycle by reciprocal multiply
  assign prod   = (2 * VW)'(work) * (2 * VW)'(u2pd_pkg::DIV10_MAGIC);
  assign quot   = VW'(prod >> u2pd_pkg::DIV10_SHIFT);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem_w  = work - quot10;
  assign rem    = rem_w[3:0];

  // final digit set, including the step in flight
  always_comb begin
    dig_fin      = digits;
    dig_fin[cnt] = rem;
  end
  assign used_fin = (rem != 4'd0) ? (TOT_W'(cnt) + TOT_W'(1)) : used;

  assign last       = (state == ST_CONV) && (cnt == LAST_CNT);
  assign sel_digits = (state == ST_HOLD) ? digits : dig_fin;
  assign sel_used   = (state == ST_HOLD) ? used : used_fin;

  // pad to the minimum count; error entries carry one character
  always_comb begin
    if (err_r) begin
      total = TOT_W'(1);
    end else if (min_r > u2pd_pkg::MIN_W'(sel_used)) begin
      total = TOT_W'(min_r);
    end else begin
      total = sel_used;
    end
  end

  assign ent_push  = (last || (state == ST_HOLD)) && !ent_full;
  assign num_ready = (state == ST_IDLE) || ent_push;
  assign accept    = num_valid && num_ready;
  assign is_err    = num.min_digits > MAX_MIN;
  assign ent       = {err_r, total, sel_digits};

  // sequencer and conversion registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else if (accept) begin
      min_r <= num.min_digits;
      err_r <= is_err;
      work  <= num.value & VAL_MASK;
      used  <= TOT_W'(1);
      cnt   <= '0;
      state <= is_err ? ST_HOLD : ST_CONV;
    end else if (ent_push) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_CONV: begin
          digits[cnt] <= rem;
          work        <= quot;
          used        <= used_fin;
          if (cnt == LAST_CNT) begin
            state <= ST_HOLD;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // an error transaction goes straight to the hand-off state
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    accept && is_err |=> state == ST_HOLD)
    else $error("error transaction did not go to hold");

  // the digit counter stays within the digit store while converting
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV |-> cnt <= LAST_CNT)
    else $error("digit counter out of range");

endmodule

// ===== src/u2pd_queue.sv =====
module u2pd_queue #(
  parameter int W = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [W-1:0]  rdata
);

  localparam int PTR_W = $clog2(u2pd_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(u2pd_pkg::Q_DEPTH + 1);

  logic [W-1:0]     mem [u2pd_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(u2pd_pkg::Q_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full)
    else $error("queue lost an entry while full");

endmodule

// ===== src/u2pd_back.sv =====
module u2pd_back #(
  parameter int MAX_DIGITS = u2pd_pkg::DEF_MAX_DIGITS,
  localparam int TOT_W = $clog2(MAX_DIGITS + 1),
  localparam int CNT_W = $clog2(MAX_DIGITS),
  localparam int ENT_W = 1 + TOT_W + 4 * MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ENT_W-1:0]  head,
  input  logic              empty,
  output logic              pop,
  output logic              chr_valid,
  input  logic              chr_ready,
  output u2pd_pkg::chr_t    chr
);

  logic [CNT_W-1:0]           k;
  logic [MAX_DIGITS-1:0][3:0] h_digits;
  logic [TOT_W-1:0]           h_total;
  logic                       h_err;
  logic [TOT_W-1:0]           pos_w;
  logic [CNT_W-1:0]           pos;
  logic                       is_last;
  logic                       accept;

  // unpack the queue head
  assign h_digits = head[4*MAX_DIGITS-1:0];
  assign h_total  = head[4*MAX_DIGITS +: TOT_W];
  assign h_err    = head[ENT_W-1];

  // most significant character first
  assign pos_w   = h_total - TOT_W'(1) - TOT_W'(k);
  assign pos     = pos_w[CNT_W-1:0];
  assign is_last = TOT_W'(k) == (h_total - TOT_W'(1));

  assign chr_valid         = !empty;
  assign chr.char_code     = h_err ? u2pd_pkg::ERROR_CHAR :
                             u2pd_pkg::DIGIT_BASE + u2pd_pkg::CHAR_W'(h_digits[pos]);
  assign chr.last_char     = is_last;
  assign chr.bad_precision = h_err;

  assign accept = chr_valid && chr_ready;
  assign pop    = accept && is_last;

  // character position within the current number
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (accept) begin
      k <= is_last ? '0 : k + CNT_W'(1);
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr.bad_precision |-> chr.last_char && k == '0)
    else $error("error transaction not a single character");

  a_pos_needs_entry: assert property (@(posedge clk) disable iff (rst)
    k != '0 |-> !empty)
    else $error("character position set without a queued number");

endmodule

// ===== src/unsigned_to_padded_decimal_core.sv =====
// conversion: a number is converted one digit a cycle, then queued, and its first
//   character is offered from the queue head; an over-range minimum queues a single 'X'
// flow: a new number can be taken in the same cycle the last one is queued; characters
//   leave one per cycle unless stalled; a two-entry queue lets both sides stall apart
// reset: synchronous, active high; clears the sequencer, the queue and the
//   character position, so nothing is offered until a new number is taken
module unsigned_to_padded_decimal_core #(
  parameter int MAX_DIGITS = u2pd_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_BITS = u2pd_pkg::DEF_VALUE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            num_valid,
  output logic            num_ready,
  input  u2pd_pkg::num_t  num,
  output logic            chr_valid,
  input  logic            chr_ready,
  output u2pd_pkg::chr_t  chr
);

  localparam int TOT_W = $clog2(MAX_DIGITS + 1);
  localparam int ENT_W = 1 + TOT_W + 4 * MAX_DIGITS;

  logic             ent_push;
  logic             ent_full;
  logic [ENT_W-1:0] ent;
  logic             q_pop;
  logic             q_empty;
  logic [ENT_W-1:0] q_head;

  // front: accept, classify and convert
  u2pd_front #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .num_valid(num_valid),
    .num_ready(num_ready),
    .num      (num),
    .ent_push (ent_push),
    .ent_full (ent_full),
    .ent      (ent)
  );

  // queue of converted numbers
  u2pd_queue #(
    .W(ENT_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (ent_push),
    .wdata(ent),
    .full (ent_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_head)
  );

  // back: emit characters
  u2pd_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .chr_valid(chr_valid),
    .chr_ready(chr_ready),
    .chr      (chr)
  );

endmodule

// ===== dv/u2pd_checker.sv =====
`timescale 1ns / 100ps

module u2pd_checker #(
  parameter int MAX_DIGITS = u2pd_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_BITS = u2pd_pkg::DEF_VALUE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           num_valid,
  input  logic           num_ready,
  input  u2pd_pkg::num_t num,
  input  logic           chr_valid,
  input  logic           chr_ready,
  input  u2pd_pkg::chr_t chr,
  output int             errors,
  output int             pending
);

  localparam int RADIX     = 10;
  localparam int MAX_PRINT = 40;

  // characters still owed by the block, oldest first
  u2pd_pkg::chr_t char_queue[$];
  u2pd_pkg::chr_t want;
  int mismatch_count = 0;
  int waiting = 0;

  assign errors  = mismatch_count;
  assign pending = waiting;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINT) begin
      $display("%0t checker: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // decimal text of one number, appended to the queue
  function automatic void predict_chars(input u2pd_pkg::num_t n);
    logic [63:0]    rest;
    logic [3:0]     digit [MAX_DIGITS];
    int             used;
    int             total;
    int             pos;
    u2pd_pkg::chr_t c;
    // minimum above the width: single error marker
    if (int'(n.min_digits) > MAX_DIGITS) begin
      c.char_code     = u2pd_pkg::ERROR_CHAR;
      c.last_char     = 1'b1;
      c.bad_precision = 1'b1;
      char_queue.push_back(c);
      return;
    end
    rest = 64'(n.value) & ((64'd1 << VALUE_BITS) - 64'd1);
    used = 1;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      digit[k] = 4'(rest % RADIX);
      rest     = rest / RADIX;
      if (digit[k] != 4'd0) begin
        used = k + 1;
      end
    end
    // zero padding up to the minimum, never below one digit
    total = used;
    if (int'(n.min_digits) > total) begin
      total = int'(n.min_digits);
    end
    for (int k = 0; k < total; k++) begin
      pos             = total - 1 - k;
      c.char_code     = u2pd_pkg::DIGIT_BASE + 7'(digit[pos]);
      c.last_char     = (k == total - 1);
      c.bad_precision = 1'b0;
      char_queue.push_back(c);
    end
  endfunction

  // compare outgoing characters, then predict from incoming numbers
  always @(posedge clk) begin
    if (rst) begin
      char_queue.delete();
    end else begin
      if (chr_valid && chr_ready) begin
        if (char_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", chr.char_code));
        end else begin
          want = char_queue.pop_front();
          if (chr.char_code !== want.char_code) begin
            report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                      chr.char_code, want.char_code));
          end
          if (chr.last_char !== want.last_char) begin
            report_mismatch($sformatf("last_char %b, wanted %b",
                                      chr.last_char, want.last_char));
          end
          if (chr.bad_precision !== want.bad_precision) begin
            report_mismatch($sformatf("bad_precision %b, wanted %b",
                                      chr.bad_precision, want.bad_precision));
          end
        end
      end
      if (num_valid && num_ready) begin
        predict_chars(num);
      end
    end
    waiting = char_queue.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_DIGITS  = u2pd_pkg::DEF_MAX_DIGITS;
  localparam int PHASE_ITEMS = 105;
  localparam int LONG_HOLD   = 80;
  localparam int RESET_LEN   = 7;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           num_valid = 1'b0;
  logic           num_ready;
  u2pd_pkg::num_t num = '0;
  logic           chr_valid;
  logic           chr_ready = 1'b0;
  u2pd_pkg::chr_t chr;
  int             errors;
  int             pending;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;

  always #1 clk = ~clk;

  unsigned_to_padded_decimal_core dut (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr)
  );

  u2pd_checker char_check (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr),
    .errors    (errors),
    .pending   (pending)
  );

  // offer one number, entered and left at a falling edge
  task automatic send_number(input logic [15:0] v, input logic [3:0] m);
    while ($urandom_range(99) < idle_pct) begin
      num_valid = 1'b0;
      @(negedge clk);
    end
    num_valid      = 1'b1;
    num.value      = v;
    num.min_digits = m;
    @(posedge clk);
    while (!num_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // mix of short, boundary and full-range numbers, some bad minimums
  function automatic u2pd_pkg::num_t random_number();
    u2pd_pkg::num_t n;
    int unsigned    p;
    case ($urandom_range(5))
      0: n.value = 16'($urandom_range(9));
      1: n.value = 16'($urandom_range(999));
      2: begin
        p       = 10 ** $urandom_range(1, 4);
        n.value = 16'(p + $urandom_range(2) - 1);
      end
      default: n.value = 16'($urandom);
    endcase
    if ($urandom_range(9) == 0) begin
      n.min_digits = 4'($urandom_range(15, MAX_DIGITS + 1));
    end else begin
      n.min_digits = 4'($urandom_range(MAX_DIGITS));
    end
    return n;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        chr_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      chr_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #200000;
    $display("testbench: errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    u2pd_pkg::num_t n;
    repeat (RESET_LEN) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, padding edges, error minimums
    send_number(16'd0,     4'd0);
    send_number(16'd0,     4'd1);
    send_number(16'd0,     4'd6);
    send_number(16'd65535, 4'd0);
    send_number(16'd65535, 4'd5);
    send_number(16'd65535, 4'd6);
    send_number(16'd65535, 4'd7);
    send_number(16'd0,     4'd15);
    send_number(16'd12345, 4'd3);
    send_number(16'd100,   4'd6);
    send_number(16'd9,     4'd2);
    send_number(16'd10,    4'd0);
    send_number(16'd1,     4'd6);
    send_number(16'd10000, 4'd5);
    send_number(16'd9999,  4'd4);
    send_number(16'hAAAA,  4'd8);
    send_number(16'h5555,  4'd2);
    send_number(16'd40960, 4'd10);
    send_number(16'd7,     4'd0);

    // random phases: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 0 && i == 20) begin
          hold_request = 1'b1;
        end
        n = random_number();
        send_number(n.value, n.min_digits);
      end
    end
    num_valid = 1'b0;

    // drain, then wait on for stray characters before the verdict
    wait (pending == 0);
    repeat (4 * MAX_DIGITS) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/u2pd_pkg.sv
src/u2pd_front.sv
src/u2pd_queue.sv
src/u2pd_back.sv
src/unsigned_to_padded_decimal_core.sv
dv/u2pd_checker.sv
dv/testbench.sv
